[sv/dre_pkg.sv]
// Shared types, widths, command and status codes for the DLT reprojection error core.
// Used by every module of the block; depends on nothing.
`default_nettype none
package dre_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 24;
  localparam int REL_FRAC_BITS   = 16;
  localparam int NUM_COEFS       = 11;
  localparam int NUM_PRODS       = 9;
  localparam int COEF_IDX_W      = $clog2(NUM_COEFS);
  localparam int CMD_W           = 2;
  localparam int IDX_W           = 4;
  localparam int DATA_W          = 32;
  localparam int NUM_W           = 50;
  localparam int QUO_W           = 32;
  localparam int DVD_W           = NUM_W + COORD_FRAC_BITS;
  localparam int DSR_W           = NUM_W;
  localparam int OP_W            = DATA_W + 1;
  localparam int PROD_W          = 2 * OP_W;
  localparam int RAD_W           = 64;
  localparam int ROOT_W          = RAD_W / 2;
  localparam int REL_W           = 24;
  localparam int SUM_W           = 48;
  localparam int CNT_W           = 16;
  localparam int STAT_W          = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROJECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORIGIN   = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] GRP_DEN  = 2'd0;
  localparam logic [1:0] GRP_U    = 2'd1;
  localparam logic [1:0] GRP_V    = 2'd2;
  localparam logic [1:0] GRP_NONE = 2'd3;

  typedef struct packed {
    logic [COEF_IDX_W-1:0] coef;
    logic [1:0]            axis;
    logic [1:0]            grp;
  } prod_sel_t;

  // Order of the nine products: denominator terms first, then u, then v.
  function automatic prod_sel_t prod_sel(input logic [3:0] k);
    prod_sel_t s;
    unique case (k)
      4'd0:    s = '{coef: 4'd8,  axis: AX_X, grp: GRP_DEN};
      4'd1:    s = '{coef: 4'd9,  axis: AX_Y, grp: GRP_DEN};
      4'd2:    s = '{coef: 4'd10, axis: AX_Z, grp: GRP_DEN};
      4'd3:    s = '{coef: 4'd0,  axis: AX_X, grp: GRP_U};
      4'd4:    s = '{coef: 4'd1,  axis: AX_Y, grp: GRP_U};
      4'd5:    s = '{coef: 4'd2,  axis: AX_Z, grp: GRP_U};
      4'd6:    s = '{coef: 4'd4,  axis: AX_X, grp: GRP_V};
      4'd7:    s = '{coef: 4'd5,  axis: AX_Y, grp: GRP_V};
      4'd8:    s = '{coef: 4'd6,  axis: AX_Z, grp: GRP_V};
      default: s = '{coef: 4'd0,  axis: AX_X, grp: GRP_NONE};
    endcase
    return s;
  endfunction

  function automatic logic [NUM_W-1:0] mag(input logic signed [NUM_W-1:0] v);
    return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
  endfunction

endpackage
`default_nettype wire

[sv/dre_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on dre_pkg for operand and product widths.
`default_nettype none
module dre_mul (
  input  wire logic                              clk_i,
  input  wire logic signed [dre_pkg::OP_W-1:0]   a_i,
  input  wire logic signed [dre_pkg::OP_W-1:0]   b_i,
  output logic signed [dre_pkg::PROD_W-1:0]      p_o
);
  import dre_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

[sv/dre_div.sv]
// Restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on dre_pkg for widths.
`default_nettype none
module dre_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dre_pkg::DVD_W-1:0]   dvd_i,
  input  wire logic [dre_pkg::DSR_W-1:0]   dsr_i,
  output logic                             done_o,
  output logic                             sat_o,
  output logic [dre_pkg::QUO_W-1:0]        quo_o
);
  import dre_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);
  localparam int HI_W = DVD_W - QUO_W;

  logic             busy_q, done_q, sat_q;
  logic [CW-1:0]    cnt_q;
  logic [DSR_W:0]   rem_q, rem_sh, rem_diff;
  logic [QUO_W-1:0] low_q, quo_q;
  logic [DSR_W-1:0] dsr_q;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_q[DSR_W-1:0], low_q[QUO_W-1]};
    ge       = rem_sh >= {1'b0, dsr_q};
    rem_diff = rem_sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= {{(DSR_W + QUO_W - DVD_W){1'b0}}, dvd_i} >= {dsr_i, {QUO_W{1'b0}}};
      rem_q <= {{(DSR_W + 1 - HI_W){1'b0}}, dvd_i[DVD_W-1:QUO_W]};
      low_q <= dvd_i[QUO_W-1:0];
      dsr_q <= dsr_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_diff : rem_sh;
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[sv/dre_sqrt.sv]
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on dre_pkg for widths.
`default_nettype none
module dre_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dre_pkg::RAD_W-1:0]   rad_i,
  output logic                             done_o,
  output logic [dre_pkg::ROOT_W-1:0]       root_o
);
  import dre_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+1:0] rem_q, rem_sh, trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
    trial  = {root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

[sv/dlt_reprojection_error_core.sv]
// Top level of the DLT reprojection error core: coefficient table, sequencer and sums.
// Depends on dre_pkg, dre_mul, dre_div and dre_sqrt.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-----------------------------------------------
//   input   | in_valid_i / in_ready_o | command, coef_index, coef_value, world, pixel
//   output  | out_valid_o/out_ready_i | projection, errors, sums, count, status
//
// A load or clear request gives no result.
// A project request uses the shared multiplier pass and then up to five runs of the divider
// and root units, fewer when the denominator is zero or the measured pixel is at the origin.
// Reset clears the coefficient table, the sums and the count.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module dlt_reprojection_error_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [dre_pkg::CMD_W-1:0]            command_i,
  input  wire logic [dre_pkg::IDX_W-1:0]            coef_index_i,
  input  wire logic signed [dre_pkg::DATA_W-1:0]    coef_value_i,
  input  wire logic signed [dre_pkg::DATA_W-1:0]    x_world_i,
  input  wire logic signed [dre_pkg::DATA_W-1:0]    y_world_i,
  input  wire logic signed [dre_pkg::DATA_W-1:0]    z_world_i,
  input  wire logic signed [dre_pkg::DATA_W-1:0]    u_measured_i,
  input  wire logic signed [dre_pkg::DATA_W-1:0]    v_measured_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [dre_pkg::DATA_W-1:0]         u_projected_o,
  output logic signed [dre_pkg::DATA_W-1:0]         v_projected_o,
  output logic [dre_pkg::DATA_W-1:0]                reproj_error_o,
  output logic [dre_pkg::REL_W-1:0]                 relative_error_o,
  output logic [dre_pkg::SUM_W-1:0]                 error_sum_o,
  output logic [dre_pkg::SUM_W-1:0]                 relative_sum_o,
  output logic [dre_pkg::CNT_W-1:0]                 point_count_o,
  output logic [dre_pkg::STAT_W-1:0]                status_o
);
  import dre_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DEN, S_DIVU, S_WDIVU, S_DIVV, S_WDIVV, S_DIFF,
    S_SQ, S_SQRTE, S_WSQRTE, S_SQRTL, S_WSQRTL, S_REL, S_WREL, S_DONE
  } state_e;

  state_e                   state_q;
  logic [DATA_W-1:0]        coef_q [NUM_COEFS];
  logic signed [DATA_W-1:0] x_q, y_q, z_q, um_q, vm_q;
  logic [3:0]               step_q;
  logic signed [NUM_W-1:0]  den_q, un_q, vn_q;
  logic [DATA_W-1:0]        up_q, vp_q, duh_q, dvh_q, err_q, len_q;
  logic                     dsh_q;
  logic [RAD_W-1:0]         e2_q, l2_q;
  logic [REL_W-1:0]         rel_q;
  logic [STAT_W-1:0]        status_q;
  logic [SUM_W-1:0]         err_acc_q, rel_acc_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_u_q, out_v_q, out_err_q;
  logic [REL_W-1:0]         out_rel_q;
  logic [SUM_W-1:0]         out_esum_q, out_rsum_q;
  logic [CNT_W-1:0]         out_cnt_q;
  logic [STAT_W-1:0]        out_stat_q;

  prod_sel_t                cur_sel, prv_sel;
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [NUM_W-1:0]  term;
  logic                     div_start, div_done, div_sat;
  logic [DVD_W-1:0]         div_dvd;
  logic [DSR_W-1:0]         div_dsr;
  logic [QUO_W-1:0]         div_q;
  logic                     sq_start, sq_done;
  logic [RAD_W-1:0]         sq_rad;
  logic [ROOT_W-1:0]        sq_root;
  logic                     neg;
  logic [DATA_W:0]          lim, qcap, qsgn;
  logic signed [DATA_W:0]   du, dv;
  logic [DATA_W-1:0]        dumag, dvmag;
  logic                     dsh;
  logic [DATA_W:0]          err_w;
  logic [DATA_W-1:0]        err_cap;
  logic [REL_W-1:0]         rel_cap;
  logic [SUM_W:0]           esum, rsum;
  logic [SUM_W-1:0]         esum_cap, rsum_cap;
  logic                     in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  dre_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dsr_i   (div_dsr),
    .done_o  (div_done),
    .sat_o   (div_sat),
    .quo_o   (div_q)
  );

  dre_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    cur_sel = prod_sel(step_q);
    prv_sel = prod_sel(step_q - 4'd1);
    mul_a   = '0;
    mul_b   = '0;
    if (state_q == S_MUL) begin
      mul_a = OP_W'(signed'(coef_q[cur_sel.coef]));
      case (cur_sel.axis)
        AX_X:    mul_b = OP_W'(x_q);
        AX_Y:    mul_b = OP_W'(y_q);
        default: mul_b = OP_W'(z_q);
      endcase
    end else if (state_q == S_SQ) begin
      case (step_q)
        4'd0: begin
          mul_a = signed'({1'b0, duh_q});
          mul_b = signed'({1'b0, duh_q});
        end
        4'd1: begin
          mul_a = signed'({1'b0, dvh_q});
          mul_b = signed'({1'b0, dvh_q});
        end
        4'd2: begin
          mul_a = OP_W'(um_q);
          mul_b = OP_W'(um_q);
        end
        default: begin
          mul_a = OP_W'(vm_q);
          mul_b = OP_W'(vm_q);
        end
      endcase
    end
    term = NUM_W'(mul_p >>> COORD_FRAC_BITS);
  end

  always_comb begin
    div_start = (state_q == S_DIVU) || (state_q == S_DIVV) || (state_q == S_REL);
    div_dvd   = '0;
    div_dsr   = mag(den_q);
    case (state_q)
      S_DIVU:  div_dvd = {mag(un_q), {COORD_FRAC_BITS{1'b0}}};
      S_DIVV:  div_dvd = {mag(vn_q), {COORD_FRAC_BITS{1'b0}}};
      S_REL: begin
        div_dvd = DVD_W'({err_q, {REL_FRAC_BITS{1'b0}}});
        div_dsr = DSR_W'(len_q);
      end
      default: div_dvd = '0;
    endcase
    sq_start = (state_q == S_SQRTE) || (state_q == S_SQRTL);
    sq_rad   = (state_q == S_SQRTE) ? e2_q : l2_q;
  end

  always_comb begin
    neg  = ((state_q == S_WDIVV) ? vn_q[NUM_W-1] : un_q[NUM_W-1]) ^ den_q[NUM_W-1];
    lim  = neg ? {1'b0, 1'b1, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
    qcap = (div_sat || ({1'b0, div_q} > lim)) ? lim : {1'b0, div_q};
    qsgn = neg ? -qcap : qcap;

    du    = signed'({up_q[DATA_W-1], up_q}) - signed'({um_q[DATA_W-1], um_q});
    dv    = signed'({vp_q[DATA_W-1], vp_q}) - signed'({vm_q[DATA_W-1], vm_q});
    dumag = du[DATA_W] ? DATA_W'(-du) : DATA_W'(du);
    dvmag = dv[DATA_W] ? DATA_W'(-dv) : DATA_W'(dv);
    dsh   = dumag[DATA_W-1] | dvmag[DATA_W-1];

    err_w   = {1'b0, sq_root} << dsh_q;
    err_cap = err_w[DATA_W] ? '1 : err_w[DATA_W-1:0];

    rel_cap = (div_sat || (|div_q[QUO_W-1:REL_W])) ? '1 : div_q[REL_W-1:0];
    esum    = {1'b0, err_acc_q} + (SUM_W + 1)'(err_q);
    rsum    = {1'b0, rel_acc_q} + (SUM_W + 1)'(rel_cap);
    esum_cap = esum[SUM_W] ? '1 : esum[SUM_W-1:0];
    rsum_cap = rsum[SUM_W] ? '1 : rsum[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= '0;
      err_acc_q   <= '0;
      rel_acc_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (command_i)
              CMD_LOAD: begin
                if (coef_index_i < IDX_W'(NUM_COEFS)) begin
                  coef_q[coef_index_i[COEF_IDX_W-1:0]] <= coef_value_i;
                end
              end
              CMD_CLEAR: begin
                err_acc_q <= '0;
                rel_acc_q <= '0;
                cnt_q     <= '0;
              end
              CMD_PROJECT: begin
                x_q     <= x_world_i;
                y_q     <= y_world_i;
                z_q     <= z_world_i;
                um_q    <= u_measured_i;
                vm_q    <= v_measured_i;
                den_q   <= NUM_W'(1) << COEF_FRAC_BITS;
                un_q    <= NUM_W'(signed'(coef_q[3]));
                vn_q    <= NUM_W'(signed'(coef_q[7]));
                step_q  <= '0;
                state_q <= S_MUL;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          step_q <= step_q + 4'd1;
          if (step_q != 4'd0) begin
            case (prv_sel.grp)
              GRP_DEN: den_q <= den_q + term;
              GRP_U:   un_q  <= un_q + term;
              GRP_V:   vn_q  <= vn_q + term;
              default: den_q <= den_q;
            endcase
          end
          if (step_q == 4'(NUM_PRODS)) state_q <= S_DEN;
        end
        S_DEN: begin
          if (den_q == '0) begin
            status_q <= ST_ZERO_DEN;
            up_q     <= '0;
            vp_q     <= '0;
            err_q    <= '0;
            rel_q    <= '0;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_DIVU;
          end
        end
        S_DIVU: state_q <= S_WDIVU;
        S_WDIVU: begin
          if (div_done) begin
            up_q    <= qsgn[DATA_W-1:0];
            state_q <= S_DIVV;
          end
        end
        S_DIVV: state_q <= S_WDIVV;
        S_WDIVV: begin
          if (div_done) begin
            vp_q    <= qsgn[DATA_W-1:0];
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          dsh_q   <= dsh;
          duh_q   <= dsh ? (dumag >> 1) : dumag;
          dvh_q   <= dsh ? (dvmag >> 1) : dvmag;
          step_q  <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          step_q <= step_q + 4'd1;
          case (step_q)
            4'd1: e2_q <= mul_p[RAD_W-1:0];
            4'd2: e2_q <= e2_q + mul_p[RAD_W-1:0];
            4'd3: l2_q <= mul_p[RAD_W-1:0];
            4'd4: begin
              l2_q    <= l2_q + mul_p[RAD_W-1:0];
              state_q <= S_SQRTE;
            end
            default: e2_q <= e2_q;
          endcase
        end
        S_SQRTE: state_q <= S_WSQRTE;
        S_WSQRTE: begin
          if (sq_done) begin
            err_q   <= err_cap;
            state_q <= S_SQRTL;
          end
        end
        S_SQRTL: state_q <= S_WSQRTL;
        S_WSQRTL: begin
          if (sq_done) begin
            len_q <= sq_root;
            if (sq_root == '0) begin
              status_q <= ST_ORIGIN;
              rel_q    <= '0;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_REL;
            end
          end
        end
        S_REL: state_q <= S_WREL;
        S_WREL: begin
          if (div_done) begin
            rel_q     <= rel_cap;
            err_acc_q <= esum_cap;
            rel_acc_q <= rsum_cap;
            if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
            status_q  <= ST_OK;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_u_q     <= up_q;
            out_v_q     <= vp_q;
            out_err_q   <= err_q;
            out_rel_q   <= rel_q;
            out_esum_q  <= err_acc_q;
            out_rsum_q  <= rel_acc_q;
            out_cnt_q   <= cnt_q;
            out_stat_q  <= status_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign u_projected_o    = out_u_q;
  assign v_projected_o    = out_v_q;
  assign reproj_error_o   = out_err_q;
  assign relative_error_o = out_rel_q;
  assign error_sum_o      = out_esum_q;
  assign relative_sum_o   = out_rsum_q;
  assign point_count_o    = out_cnt_q;
  assign status_o         = out_stat_q;

endmodule
`default_nettype wire
